FILE: hdl/ilst_pkg.sv
// ilst_pkg: shared constants, codes and types for the indexed list engine
// no dependencies; used by the interfaces, the cell and the top level
`default_nettype none

package ilst_pkg;

  // storage size and field widths
  localparam int CAPACITY = 64;
  localparam int POS_W    = $clog2(CAPACITY);
  localparam int CMD_W    = 3;
  localparam int INDEX_W  = 7;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_AT   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REM_HEAD = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REM_AT   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ_AT  = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  // per-cell load selects, at most one set in a cycle
  typedef struct packed {
    logic load_left;
    logic load_right;
    logic load_new;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/ilst_if.sv
// ilst_req_if / ilst_rsp_if: valid-ready channels for commands and results
// depends on ilst_pkg for field widths
`default_nettype none

interface ilst_req_if;
  import ilst_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic [INDEX_W-1:0]        index;
  logic signed [DATA_W-1:0]  value;

  modport source (output valid, output cmd, output index, output value, input ready);
  modport sink   (input valid, input cmd, input index, input value, output ready);
endinterface

interface ilst_rsp_if;
  import ilst_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [DATA_W-1:0]  value_out;
  logic [STATUS_W-1:0]       status;
  logic [COUNT_W-1:0]        count;
  logic                      is_empty;

  modport source (output valid, output value_out, output status, output count,
                  output is_empty, input ready);
  modport sink   (input valid, input value_out, input status, input count,
                  input is_empty, output ready);
endinterface

`default_nettype wire

FILE: hdl/indexed_list_engine.sv
// indexed_list_engine: top level, command decode, cell chain and result register
// depends on ilst_pkg, ilst_req_if, ilst_rsp_if and ilst_cell
//
// Usage:
//   req carries one command per transaction (cmd, index, value); rsp returns
//   exactly one result per command (value_out, status, count, is_empty).
//   The list lives in a row of 64 cells; an insert shifts every cell after
//   the position one place right, a remove shifts them one place left, all
//   in the same cycle. The result is registered and shows on rsp the cycle
//   after the command transaction. Throughput: one command per cycle while
//   rsp is taken, set by the single result register.
//   When rsp is stalled, the result holds and req.ready stays low until the
//   result is taken; the list is untouched meanwhile.
//   Synchronous reset (rst) empties the list, drops rsp.valid and holds
//   req.ready low; cell contents are not cleared and positions at or beyond
//   the count are never read.
`default_nettype none

module indexed_list_engine
  import ilst_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  ilst_req_if.sink    req,
  ilst_rsp_if.source  rsp
);

  logic [COUNT_W-1:0]   count;
  logic [COUNT_W-1:0]   count_next;
  logic                 rsp_valid;
  logic                 accept;
  logic [INDEX_W-1:0]   pos;
  logic                 is_ins;
  logic                 is_rem;
  logic                 is_rd;
  logic [STATUS_W-1:0]  status_next;
  logic                 do_ins;
  logic                 do_rem;
  logic [DATA_W-1:0]    rd_data;
  logic [DATA_W-1:0]    cell_data [CAPACITY];
  cell_ctrl_t           cell_ctrl [CAPACITY];

  // accept a new command when out of reset and the result register is free or being emptied
  assign req.ready = !rst && (!rsp_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  // command decode and position select
  always_comb begin
    is_ins = 1'b0;
    is_rem = 1'b0;
    is_rd  = 1'b0;
    pos    = req.index;
    case (req.cmd)
      CMD_INS_HEAD: begin
        is_ins = 1'b1;
        pos    = '0;
      end
      CMD_INS_TAIL: begin
        is_ins = 1'b1;
        pos    = count;
      end
      CMD_INS_AT:   is_ins = 1'b1;
      CMD_REM_HEAD: begin
        is_rem = 1'b1;
        pos    = '0;
      end
      CMD_REM_AT:   is_rem = 1'b1;
      CMD_READ_AT:  is_rd  = 1'b1;
      default: ;
    endcase
  end

  // status: range check first, then the full check for inserts
  always_comb begin
    if (is_ins) begin
      if (pos > count) begin
        status_next = ST_RANGE;
      end else if (count >= COUNT_W'(CAPACITY)) begin
        status_next = ST_FULL;
      end else begin
        status_next = ST_OK;
      end
    end else if (is_rem || is_rd) begin
      status_next = (pos < count) ? ST_OK : ST_RANGE;
    end else begin
      status_next = ST_RANGE;
    end
  end

  assign do_ins = accept && is_ins && (status_next == ST_OK);
  assign do_rem = accept && is_rem && (status_next == ST_OK);

  // count update
  always_comb begin
    count_next = count;
    if (do_ins) begin
      count_next = count + COUNT_W'(1);
    end else if (do_rem) begin
      count_next = count - COUNT_W'(1);
    end
  end

  // cell chain: each cell picks its own load from its place against pos
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_data;
    logic [DATA_W-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_mid_l
      assign left_data = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_mid_r
      assign right_data = cell_data[i+1];
    end

    assign cell_ctrl[i].load_new   = do_ins && (pos == INDEX_W'(i));
    assign cell_ctrl[i].load_left  = do_ins && (pos <  INDEX_W'(i));
    assign cell_ctrl[i].load_right = do_rem && (pos <= INDEX_W'(i));

    ilst_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[i]),
      .left_data  (left_data),
      .right_data (right_data),
      .new_data   (req.value),
      .data       (cell_data[i])
    );
  end

  // read select for remove and read commands
  assign rd_data = cell_data[pos[POS_W-1:0]];

  // list length register
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.value_out <= ((is_rem || is_rd) && (status_next == ST_OK)) ? rd_data : '0;
      rsp.status    <= status_next;
      rsp.count     <= count_next;
      rsp.is_empty  <= (count_next == '0);
    end
  end

  assign rsp.valid = rsp_valid;

endmodule

`default_nettype wire

FILE: hdl/ilst_cell.sv
// ilst_cell: one list position; loads from its left or right neighbour or a new value
// depends on ilst_pkg for the data width and the control struct
`default_nettype none

module ilst_cell
  import ilst_pkg::*;
(
  input  wire logic              clk,
  input  wire cell_ctrl_t        ctrl,
  input  wire logic [DATA_W-1:0] left_data,
  input  wire logic [DATA_W-1:0] right_data,
  input  wire logic [DATA_W-1:0] new_data,
  output logic      [DATA_W-1:0] data
);

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (ctrl.load_new) begin
      data <= new_data;
    end else if (ctrl.load_left) begin
      data <= left_data;
    end else if (ctrl.load_right) begin
      data <= right_data;
    end
  end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// tb_top: self-checking bench for indexed_list_engine, driving commands on req and
// checking every result on rsp against a shadow copy of the list kept in the bench
// depends on ilst_pkg, ilst_req_if, ilst_rsp_if and the indexed_list_engine rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ilst_pkg::*;

  // command codes the block does not use
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic signed [DATA_W-1:0] value_out;
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       count;
    logic                     is_empty;
  } list_result_t;

  logic clk;
  logic rst;

  ilst_req_if req_ch ();
  ilst_rsp_if rsp_ch ();

  indexed_list_engine dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // shadow copy of the list and the results still owed by the block
  logic signed [DATA_W-1:0] shadow_cells [CAPACITY];
  int                       shadow_len;
  list_result_t             pending_results [$];
  list_result_t             head_result;

  int fail_count;
  int send_idle_pct;
  int recv_stall_pct;
  int steady_send;
  int steady_recv;
  int drain_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit, well above the slowest legal run
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // apply one command to the shadow list and return the result it must give
  function automatic list_result_t apply_list_cmd(input logic [CMD_W-1:0] c,
                                                  input logic [INDEX_W-1:0] ix,
                                                  input logic signed [DATA_W-1:0] v);
    list_result_t r;
    int pos;
    int i;
    r.value_out = '0;
    r.status    = ST_RANGE;
    case (c)
      CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT: begin
        if (c == CMD_INS_HEAD) pos = 0;
        else if (c == CMD_INS_TAIL) pos = shadow_len;
        else pos = ix;
        // range is reported ahead of full
        if (pos > shadow_len) begin
          r.status = ST_RANGE;
        end else if (shadow_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (i = shadow_len; i > pos; i--) shadow_cells[i] = shadow_cells[i-1];
          shadow_cells[pos] = v;
          shadow_len++;
          r.status = ST_OK;
        end
      end
      CMD_REM_HEAD, CMD_REM_AT: begin
        pos = (c == CMD_REM_HEAD) ? 0 : int'(ix);
        if (pos < shadow_len) begin
          r.value_out = shadow_cells[pos];
          for (i = pos; i + 1 < shadow_len; i++) shadow_cells[i] = shadow_cells[i+1];
          shadow_len--;
          r.status = ST_OK;
        end
      end
      CMD_READ_AT: begin
        if (int'(ix) < shadow_len) begin
          r.value_out = shadow_cells[ix];
          r.status    = ST_OK;
        end
      end
      default: r.status = ST_RANGE;
    endcase
    r.count    = COUNT_W'(shadow_len);
    r.is_empty = (shadow_len == 0);
    return r;
  endfunction

  // random data, with the extremes turning up often
  function automatic logic signed [DATA_W-1:0] rand_value();
    case ($urandom_range(24))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // mostly a legal position up to limit, sometimes anywhere in the field
  function automatic logic [INDEX_W-1:0] pick_index(input int limit);
    if ($urandom_range(99) < 85) return INDEX_W'($urandom_range(limit));
    return INDEX_W'($urandom_range(127));
  endfunction

  // one command transaction, with a random idle gap in front of it
  task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [INDEX_W-1:0] ix,
                          input logic signed [DATA_W-1:0] v);
    int gap;
    gap = 0;
    if (steady_send > 0) begin
      steady_send--;
    end else begin
      if ($urandom_range(49) == 0) steady_send = 20;
      while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    end
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd   <= c;
    req_ch.index <= ix;
    req_ch.value <= v;
    do @(posedge clk); while (!req_ch.ready);
    pending_results.push_back(apply_list_cmd(c, ix, v));
  endtask

  // hold the sender off until every owed result has come back
  task automatic pause_until_drained();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
    @(posedge clk);
  endtask

  // empty list errors, extremes of the fields and every command code
  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_cmd(CMD_READ_AT,  7'd0,   32'sd0);
    send_cmd(CMD_REM_HEAD, 7'd127, 32'sd0);
    send_cmd(CMD_REM_AT,   7'd127, '1);
    send_cmd(CMD_INS_AT,   7'd1,   32'sd7);
    send_cmd(CMD_INS_HEAD, 7'd127, VAL_MIN);
    send_cmd(CMD_INS_TAIL, 7'd0,   VAL_MAX);
    send_cmd(CMD_INS_AT,   7'd1,   32'sd0);
    // index equal to the count appends at the tail
    send_cmd(CMD_INS_AT,   7'd3,   '1);
    send_cmd(CMD_INS_AT,   7'd5,   32'sd9);
    send_cmd(CMD_READ_AT,  7'd0,   '1);
    send_cmd(CMD_READ_AT,  7'd3,   32'sd0);
    send_cmd(CMD_READ_AT,  7'd4,   32'sd0);
    send_cmd(CMD_READ_AT,  7'd127, 32'sd0);
    send_cmd(CMD_SPARE_6,  7'd127, '1);
    send_cmd(CMD_SPARE_7,  7'd0,   VAL_MIN);
    send_cmd(CMD_REM_AT,   7'd1,   32'sd0);
    send_cmd(CMD_REM_AT,   7'd3,   32'sd0);
    send_cmd(CMD_REM_AT,   7'd2,   32'sd0);
    send_cmd(CMD_REM_HEAD, 7'd0,   32'sd0);
    send_cmd(CMD_REM_HEAD, 7'd0,   32'sd0);
    send_cmd(CMD_REM_HEAD, 7'd0,   32'sd0);
    send_cmd(CMD_INS_AT,   7'd0,   32'sh5555_5555);
    send_cmd(CMD_REM_AT,   7'd0,   32'sd0);
  endtask

  // fill the store, push against the full edge, then empty it again
  task automatic test_full_store();
    send_idle_pct  = 24;
    recv_stall_pct = 24;
    while (shadow_len < CAPACITY) begin
      case ($urandom_range(2))
        0: send_cmd(CMD_INS_HEAD, INDEX_W'($urandom_range(127)), rand_value());
        1: send_cmd(CMD_INS_TAIL, INDEX_W'($urandom_range(127)), rand_value());
        default: send_cmd(CMD_INS_AT, pick_index(shadow_len), rand_value());
      endcase
    end
    send_cmd(CMD_INS_HEAD, 7'd0,   rand_value());
    send_cmd(CMD_INS_TAIL, 7'd127, rand_value());
    send_cmd(CMD_INS_AT,   7'd64,  rand_value());
    // out of range wins over full
    send_cmd(CMD_INS_AT,   7'd65,  rand_value());
    send_cmd(CMD_INS_AT,   7'd127, rand_value());
    send_cmd(CMD_READ_AT,  7'd63,  rand_value());
    send_cmd(CMD_READ_AT,  7'd64,  rand_value());
    send_cmd(CMD_REM_AT,   7'd63,  rand_value());
    send_cmd(CMD_INS_AT,   7'd63,  rand_value());
    send_cmd(CMD_REM_HEAD, 7'd0,   rand_value());
    send_cmd(CMD_INS_TAIL, 7'd0,   rand_value());
    pause_until_drained();
    while (shadow_len > 0) begin
      case ($urandom_range(3))
        0: send_cmd(CMD_REM_HEAD, INDEX_W'($urandom_range(127)), rand_value());
        1: send_cmd(CMD_READ_AT, pick_index(shadow_len - 1), rand_value());
        default: send_cmd(CMD_REM_AT, pick_index(shadow_len - 1), rand_value());
      endcase
    end
    send_cmd(CMD_REM_HEAD, 7'd0, rand_value());
  endtask

  // random traffic steering the fill level towards moving targets
  task automatic run_traffic_phase(input int send_pct, input int recv_pct, input int n_items);
    int i;
    int roll;
    int target;
    int grow_limit;
    int last_pos;
    logic [CMD_W-1:0]   c;
    logic [INDEX_W-1:0] ix;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    target = 0;
    for (i = 0; i < n_items; i++) begin
      if (i % 50 == 0) begin
        roll   = $urandom_range(3);
        target = (roll == 0) ? 0 : (roll == 1) ? CAPACITY : $urandom_range(CAPACITY);
      end
      if (i == n_items / 2) pause_until_drained();
      roll       = $urandom_range(99);
      grow_limit = (shadow_len < target) ? 70 : 30;
      last_pos   = (shadow_len > 0) ? shadow_len - 1 : 0;
      ix         = INDEX_W'($urandom_range(127));
      if (roll < 4) begin
        // noise: codes the block rejects
        c = (roll % 2 == 0) ? CMD_SPARE_6 : CMD_SPARE_7;
      end else if (roll < grow_limit) begin
        case ($urandom_range(2))
          0: c = CMD_INS_HEAD;
          1: c = CMD_INS_TAIL;
          default: begin
            c  = CMD_INS_AT;
            ix = pick_index(shadow_len);
          end
        endcase
      end else if (roll < 85) begin
        if ($urandom_range(1) == 0) begin
          c = CMD_REM_HEAD;
        end else begin
          c  = CMD_REM_AT;
          ix = pick_index(last_pos);
        end
      end else begin
        c  = CMD_READ_AT;
        ix = pick_index(last_pos);
      end
      send_cmd(c, ix, rand_value());
    end
  endtask

  // result side back-pressure
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (steady_recv > 0) begin
        steady_recv--;
        rsp_ch.ready <= 1'b1;
      end else begin
        if ($urandom_range(49) == 0) steady_recv = 20;
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // compare each result transaction with the oldest owed result
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no command outstanding");
        fail_count++;
      end else begin
        head_result = pending_results.pop_front();
        if (rsp_ch.value_out !== head_result.value_out) begin
          $error("value_out: expected %0d, actual %0d", head_result.value_out,
                 rsp_ch.value_out);
          fail_count++;
        end
        if (rsp_ch.status !== head_result.status) begin
          $error("status: expected %0d, actual %0d", head_result.status, rsp_ch.status);
          fail_count++;
        end
        if (rsp_ch.count !== head_result.count) begin
          $error("count: expected %0d, actual %0d", head_result.count, rsp_ch.count);
          fail_count++;
        end
        if (rsp_ch.is_empty !== head_result.is_empty) begin
          $error("is_empty: expected %0d, actual %0d", head_result.is_empty,
                 rsp_ch.is_empty);
          fail_count++;
        end
      end
    end
  end

  // reset, test sequence and final verdict
  initial begin
    rst            <= 1'b1;
    req_ch.valid   <= 1'b0;
    req_ch.cmd     <= CMD_INS_HEAD;
    req_ch.index   <= '0;
    req_ch.value   <= '0;
    shadow_len     = 0;
    fail_count     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    steady_send    = 0;
    steady_recv    = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_full_store();
    run_traffic_phase(0, 0, 340);
    run_traffic_phase(73, 0, 340);
    run_traffic_phase(0, 73, 340);
    run_traffic_phase(24, 24, 340);

    // let the last results come home, then let the bench idle before the verdict
    req_ch.valid <= 1'b0;
    for (drain_cycles = 0; drain_cycles < 1000 && pending_results.size() != 0;
         drain_cycles++) begin
      @(negedge clk);
    end
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
